FILE: rtl/lc3ie_pkg.sv
// Package: shared constants, opcodes, request types and helpers of the LC-3 execute unit.
`default_nettype none

package lc3ie_pkg;

  // Default width of the word memory address
  localparam int MEM_ADDR_BITS_DEF = 16;

  // Register state after reset
  localparam logic [15:0] START_ADDR_RST = 16'h3000;
  localparam logic [2:0]  CC_N           = 3'b100;
  localparam logic [2:0]  CC_Z           = 3'b010;
  localparam logic [2:0]  CC_P           = 3'b001;

  // Register number used for return addresses
  localparam logic [2:0] REG_LINK = 3'd7;

  // Opcodes
  localparam logic [3:0] OP_BR   = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_LD   = 4'd2;
  localparam logic [3:0] OP_ST   = 4'd3;
  localparam logic [3:0] OP_JSR  = 4'd4;
  localparam logic [3:0] OP_AND  = 4'd5;
  localparam logic [3:0] OP_LDR  = 4'd6;
  localparam logic [3:0] OP_STR  = 4'd7;
  localparam logic [3:0] OP_RTI  = 4'd8;
  localparam logic [3:0] OP_NOT  = 4'd9;
  localparam logic [3:0] OP_LDI  = 4'd10;
  localparam logic [3:0] OP_STI  = 4'd11;
  localparam logic [3:0] OP_JMP  = 4'd12;
  localparam logic [3:0] OP_RES  = 4'd13;
  localparam logic [3:0] OP_LEA  = 4'd14;
  localparam logic [3:0] OP_TRAP = 4'd15;

  // Input item kinds
  localparam logic KIND_EXEC  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  // Word memory request
  typedef struct packed {
    logic        rd_en;
    logic        wr_en;
    logic [15:0] addr;
    logic [15:0] wdata;
  } mem_req_t;

  // Register file read request, two ports
  typedef struct packed {
    logic       en;
    logic [2:0] addr_a;
    logic [2:0] addr_b;
  } rf_rd_t;

  // Register file write request
  typedef struct packed {
    logic        en;
    logic [2:0]  addr;
    logic [15:0] data;
  } rf_wr_t;

  // Condition code from a value written to a register
  function automatic logic [2:0] flags_of(input logic [15:0] v);
    logic [2:0] f;
    if (v[15]) begin
      f = CC_N;
    end else if (v == 16'd0) begin
      f = CC_Z;
    end else begin
      f = CC_P;
    end
    return f;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lc3ie_in_if.sv
// Interface: input channel carrying instruction and memory write transactions.
`default_nettype none

interface lc3ie_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] instr_word;
  logic [15:0] load_address;
  logic [15:0] load_data;

  modport source (output valid, output kind, output instr_word, output load_address,
                  output load_data, input ready);
  modport sink (input valid, input kind, input instr_word, input load_address,
                input load_data, output ready);
endinterface

`default_nettype wire

FILE: rtl/lc3ie_out_if.sv
// Interface: result channel carrying one transaction per executed item.
`default_nettype none

interface lc3ie_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pc_after;
  logic [2:0]  cond_flags;
  logic        trap_request;
  logic [7:0]  trap_number;
  logic        illegal_op;

  modport source (output valid, output pc_after, output cond_flags, output trap_request,
                  output trap_number, output illegal_op, input ready);
  modport sink (input valid, input pc_after, input cond_flags, input trap_request,
                input trap_number, input illegal_op, output ready);
endinterface

`default_nettype wire

FILE: rtl/lc3_instruction_execute.sv
// Module: LC-3 instruction execute unit, top level with the instruction sequencer.
`default_nettype none

// Executes one LC-3 instruction per input transaction against its own eight registers,
// program counter, condition code and word memory; a write transaction stores one
// memory word. Each transaction yields exactly one result transaction. The first
// cycle after a transaction is accepted reads the register file; operate, branch,
// jump, trap, ST, STR and memory write transactions finish in that cycle, so they run
// at one per cycle unless the output stalls. LD, LDR, LDI and STI go on to S_MEM1 and
// LDI to S_MEM2, as the registered word memory is read once per dependent address.
// The next transaction is accepted in the cycle the current one finishes, while the
// result waits in the output register. Writing start_address also loads the program
// counter; the user must write configuration only while the unit is idle, which the block itself does not enforce.
module lc3_instruction_execute #(
  parameter int MEM_ADDR_BITS = lc3ie_pkg::MEM_ADDR_BITS_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  lc3ie_in_if.sink    in_ch,
  lc3ie_out_if.source out_ch,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [2:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lc3ie_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_MEM1 = 2'd2;
  localparam logic [1:0] S_MEM2 = 2'd3;

  logic [1:0]  state_r;
  logic [1:0]  state_nxt;
  logic [15:0] start_r;
  logic [15:0] pc_r;
  logic [15:0] pc_nxt;
  logic [2:0]  cc_r;
  logic [2:0]  cc_nxt;

  // Current transaction
  logic        kind_r;
  logic [15:0] ins_r;
  logic [15:0] laddr_r;
  logic [15:0] ldata_r;

  // Output register
  logic        out_valid_r;
  logic [15:0] out_pc_r;
  logic [2:0]  out_cc_r;
  logic        out_trap_r;
  logic [7:0]  out_num_r;
  logic        out_ill_r;

  mem_req_t    mem_req;
  logic [15:0] mem_rdata;
  rf_rd_t      rf_rd;
  rf_wr_t      rf_wr;
  logic [15:0] rf_a;
  logic [15:0] rf_b;

  logic        cfg_wr;
  logic        slot_free;
  logic        finish;
  logic        done;
  logic        accept;
  logic [3:0]  in_op;

  logic [3:0]  op;
  logic [2:0]  dr;
  logic [15:0] off9;
  logic [15:0] off11;
  logic [15:0] off6;
  logic [15:0] imm5;
  logic [15:0] pc_inc;
  logic [15:0] pc_off9;
  logic [15:0] base_off6;

  logic        mem_wr;
  logic        reg_we;
  logic [2:0]  reg_addr;
  logic [15:0] reg_val;
  logic        set_cc;
  logic        res_trap;
  logic        res_ill;

  // Configuration port: one register at byte address 0.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {16'd0, start_r};

  // Field extraction of the current instruction.
  assign op        = ins_r[15:12];
  assign dr        = ins_r[11:9];
  assign off9      = {{7{ins_r[8]}}, ins_r[8:0]};
  assign off11     = {{5{ins_r[10]}}, ins_r[10:0]};
  assign off6      = {{10{ins_r[5]}}, ins_r[5:0]};
  assign imm5      = {{11{ins_r[4]}}, ins_r[4:0]};
  assign pc_inc    = pc_r + 16'd1;
  assign pc_off9   = pc_inc + off9;
  assign base_off6 = rf_a + off6;

  // Handshake: a transaction finishing now frees the unit for the next one.
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign done        = finish && slot_free;
  assign in_ch.ready = (state_r == S_IDLE) || done;
  assign accept      = in_ch.valid && in_ch.ready;

  // Register reads are issued as the transaction is accepted.
  assign in_op       = in_ch.instr_word[15:12];
  assign rf_rd.en     = accept;
  assign rf_rd.addr_a = in_ch.instr_word[8:6];
  assign rf_rd.addr_b = (in_op inside {OP_ST, OP_STR, OP_STI}) ? in_ch.instr_word[11:9]
                                                               : in_ch.instr_word[2:0];

  // Sequencer and datapath.
  always_comb begin
    state_nxt     = state_r;
    finish        = 1'b0;
    mem_wr        = 1'b0;
    mem_req.rd_en = 1'b0;
    mem_req.addr  = pc_off9;
    mem_req.wdata = rf_b;
    reg_we        = 1'b0;
    reg_addr      = dr;
    reg_val       = 16'd0;
    set_cc        = 1'b0;
    pc_nxt        = pc_r;
    res_trap      = 1'b0;
    res_ill       = 1'b0;
    case (state_r)
      S_EXEC: begin
        if (kind_r == KIND_WRITE) begin
          finish        = 1'b1;
          mem_wr        = 1'b1;
          mem_req.addr  = laddr_r;
          mem_req.wdata = ldata_r;
        end else begin
          pc_nxt = pc_inc;
          case (op)
            OP_BR: begin
              finish = 1'b1;
              if ((dr & cc_r) != 3'd0) begin
                pc_nxt = pc_off9;
              end
            end
            OP_ADD: begin
              finish  = 1'b1;
              reg_we  = 1'b1;
              set_cc  = 1'b1;
              reg_val = rf_a + (ins_r[5] ? imm5 : rf_b);
            end
            OP_AND: begin
              finish  = 1'b1;
              reg_we  = 1'b1;
              set_cc  = 1'b1;
              reg_val = rf_a & (ins_r[5] ? imm5 : rf_b);
            end
            OP_NOT: begin
              finish  = 1'b1;
              reg_we  = 1'b1;
              set_cc  = 1'b1;
              reg_val = ~rf_a;
            end
            OP_LEA: begin
              finish  = 1'b1;
              reg_we  = 1'b1;
              set_cc  = 1'b1;
              reg_val = pc_off9;
            end
            OP_LD, OP_LDI, OP_STI: begin
              mem_req.rd_en = 1'b1;
              state_nxt     = S_MEM1;
            end
            OP_LDR: begin
              mem_req.rd_en = 1'b1;
              mem_req.addr  = base_off6;
              state_nxt     = S_MEM1;
            end
            OP_ST: begin
              finish = 1'b1;
              mem_wr = 1'b1;
            end
            OP_STR: begin
              finish       = 1'b1;
              mem_wr       = 1'b1;
              mem_req.addr = base_off6;
            end
            OP_JSR: begin
              // Target is formed from the old register value before the link write.
              finish   = 1'b1;
              reg_we   = 1'b1;
              reg_addr = REG_LINK;
              reg_val  = pc_inc;
              pc_nxt   = ins_r[11] ? (pc_inc + off11) : rf_a;
            end
            OP_JMP: begin
              finish = 1'b1;
              pc_nxt = rf_a;
            end
            OP_TRAP: begin
              finish   = 1'b1;
              reg_we   = 1'b1;
              reg_addr = REG_LINK;
              reg_val  = pc_inc;
              res_trap = 1'b1;
            end
            default: begin
              // Return from interrupt and the reserved opcode leave all state alone.
              finish  = 1'b1;
              res_ill = 1'b1;
              pc_nxt  = pc_r;
            end
          endcase
        end
      end
      S_MEM1: begin
        pc_nxt = pc_inc;
        case (op)
          OP_LDI: begin
            mem_req.rd_en = 1'b1;
            mem_req.addr  = mem_rdata;
            state_nxt     = S_MEM2;
          end
          OP_STI: begin
            finish       = 1'b1;
            mem_wr       = 1'b1;
            mem_req.addr = mem_rdata;
          end
          default: begin
            finish  = 1'b1;
            reg_we  = 1'b1;
            set_cc  = 1'b1;
            reg_val = mem_rdata;
          end
        endcase
      end
      S_MEM2: begin
        pc_nxt  = pc_inc;
        finish  = 1'b1;
        reg_we  = 1'b1;
        set_cc  = 1'b1;
        reg_val = mem_rdata;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Side effects take place only when the result can be delivered.
    mem_req.wr_en = mem_wr && done;
    rf_wr.en      = reg_we && done;
    rf_wr.addr    = reg_addr;
    rf_wr.data    = reg_val;
    cc_nxt        = set_cc ? flags_of(reg_val) : cc_r;

    if (done || (state_r == S_IDLE)) begin
      state_nxt = accept ? S_EXEC : S_IDLE;
    end
  end

  // Control state, program counter and condition code.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      start_r     <= START_ADDR_RST;
      pc_r        <= START_ADDR_RST;
      cc_r        <= CC_Z;
    end else begin
      state_r <= state_nxt;
      if (done) begin
        out_valid_r <= 1'b1;
        pc_r        <= pc_nxt;
        cc_r        <= cc_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr) begin
        start_r <= cfg_pwdata[15:0];
        pc_r    <= cfg_pwdata[15:0];
      end
    end
  end

  // Payload registers of the current transaction and of the result.
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= in_ch.kind;
      ins_r   <= in_ch.instr_word;
      laddr_r <= in_ch.load_address;
      ldata_r <= in_ch.load_data;
    end
    if (done) begin
      out_pc_r   <= pc_nxt;
      out_cc_r   <= cc_nxt;
      out_trap_r <= res_trap;
      out_num_r  <= res_trap ? ins_r[7:0] : 8'd0;
      out_ill_r  <= res_ill;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pc_after     = out_pc_r;
  assign out_ch.cond_flags   = out_cc_r;
  assign out_ch.trap_request = out_trap_r;
  assign out_ch.trap_number  = out_num_r;
  assign out_ch.illegal_op   = out_ill_r;

  // Register file and word memory.
  lc3ie_regfile u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_req    (rf_rd),
    .wr_req    (rf_wr),
    .rd_data_a (rf_a),
    .rd_data_b (rf_b)
  );

  lc3ie_wordmem #(
    .ADDR_BITS (MEM_ADDR_BITS)
  ) u_wordmem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // Only the indirect load reaches the second memory stage.
  a_mem2_ldi : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MEM2) |-> (op == OP_LDI))
    else $error("second memory stage entered by an instruction other than LDI");

  // The first memory stage is reached only by memory reading instructions.
  a_mem1_ops : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MEM1) |-> ((kind_r == KIND_EXEC) &&
      ((op == OP_LD) || (op == OP_LDR) || (op == OP_LDI) || (op == OP_STI))))
    else $error("memory stage entered by an instruction that does not read memory");

  // An illegal instruction leaves the program counter and condition code unchanged.
  a_illegal_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (done && res_ill && !cfg_wr) |=> ((pc_r == $past(pc_r)) && (cc_r == $past(cc_r))))
    else $error("illegal instruction changed the program counter or flags");

  // A finished transaction always presents a result in the next cycle.
  a_done_out : assert property (@(posedge clk) disable iff (!rst_n)
    done |=> out_valid_r)
    else $error("finished transaction did not load the output register");

  // Register writes happen only when a transaction finishes.
  a_rf_wr_done : assert property (@(posedge clk) disable iff (!rst_n)
    rf_wr.en |-> (done && (kind_r == KIND_EXEC)))
    else $error("register write outside a finishing instruction");

endmodule

`default_nettype wire

FILE: rtl/lc3ie_regfile.sv
// Module: eight-entry general register memory with two registered read ports.
`default_nettype none

module lc3ie_regfile (
  input  wire                 clk,
  input  wire                 rst_n,
  input  lc3ie_pkg::rf_rd_t   rd_req,
  input  lc3ie_pkg::rf_wr_t   wr_req,
  output logic [15:0]         rd_data_a,
  output logic [15:0]         rd_data_b
);
  import lc3ie_pkg::*;

  logic [15:0] regs [8];
  logic [7:0]  valid_r;
  logic [15:0] rd_a_r;
  logic [15:0] rd_b_r;

  // Valid bits: an entry not yet written reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 8'd0;
    end else if (wr_req.en) begin
      valid_r[wr_req.addr] <= 1'b1;
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      regs[wr_req.addr] <= wr_req.data;
    end
  end

  // Registered reads; a write in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      if (wr_req.en && (wr_req.addr == rd_req.addr_a)) begin
        rd_a_r <= wr_req.data;
      end else begin
        rd_a_r <= valid_r[rd_req.addr_a] ? regs[rd_req.addr_a] : 16'd0;
      end
      if (wr_req.en && (wr_req.addr == rd_req.addr_b)) begin
        rd_b_r <= wr_req.data;
      end else begin
        rd_b_r <= valid_r[rd_req.addr_b] ? regs[rd_req.addr_b] : 16'd0;
      end
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

`default_nettype wire

FILE: rtl/lc3ie_wordmem.sv
// Module: single-port word memory with a registered read.
`default_nettype none

module lc3ie_wordmem #(
  parameter int ADDR_BITS = lc3ie_pkg::MEM_ADDR_BITS_DEF
) (
  input  wire                  clk,
  input  lc3ie_pkg::mem_req_t  req,
  output logic [15:0]          rdata
);
  import lc3ie_pkg::*;

  localparam int WORDS = 1 << ADDR_BITS;

  logic [15:0]          mem [WORDS];
  logic [15:0]          rdata_r;
  logic [ADDR_BITS-1:0] idx;

  // Only the low address bits select the word.
  assign idx = req.addr[ADDR_BITS-1:0];

  // Write and read ports.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[idx] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata_r <= mem[idx];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire
